### hw/rtl/fwcpid_pkg.sv
// fwcpid_pkg: widths, codes, reset values and shared types of the cascaded wheel regulator
// no dependencies; every other file of the block uses it by scoped names

package fwcpid_pkg;

   // wheel count and gain format
   localparam int WHEELS         = 4;
   localparam int GAIN_FRAC_BITS = 12;
   localparam int WHEEL_IDX_W    = (WHEELS > 1) ? $clog2(WHEELS) : 1;

   // field widths
   localparam int REQ_TYPE_W    = 2;
   localparam int WHEEL_FIELD_W = 2;
   localparam int DRIVE_W       = 16;
   localparam int DRIVE_FIELDS  = 4;
   localparam int COUNT_W       = 16;
   localparam int GAIN_W        = 16;

   // datapath widths
   localparam int DERR_W  = COUNT_W + 1;            // distance error
   localparam int DDIFF_W = DERR_W + 1;             // distance error change
   localparam int SUM_W   = 32;                     // error sum, speed target, speed error
   localparam int SDIFF_W = SUM_W + 1;              // speed error change
   localparam int PROD_W  = GAIN_W + 1 + SDIFF_W;   // one product of the shared multiplier
   localparam int ACC_W   = PROD_W + 2;             // sum of up to three products
   localparam int SCL_W   = ACC_W - GAIN_FRAC_BITS; // accumulator after the gain shift

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST_KP  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST_KI  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST_KD  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_KP = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_KI = 3'd5;

   localparam logic [CSR_DATA_W-1:0] TARGET_RST   = 16'd690;
   localparam logic [CSR_DATA_W-1:0] DIST_KP_RST  = 16'd614;
   localparam logic [CSR_DATA_W-1:0] DIST_KI_RST  = 16'd0;
   localparam logic [CSR_DATA_W-1:0] DIST_KD_RST  = 16'd819;
   localparam logic [CSR_DATA_W-1:0] SPEED_KP_RST = 16'd410;
   localparam logic [CSR_DATA_W-1:0] SPEED_KI_RST = 16'd410;

   // request codes on the input channel
   localparam logic [REQ_TYPE_W-1:0] REQ_PULSE = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_TICK  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_START = 2'd2;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_REPORT,
      CMD_PULSE,
      CMD_TICK,
      CMD_START
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic [WHEEL_IDX_W-1:0] wheel;
   } cmd_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] target_pulses;
      logic [GAIN_W-1:0]     dist_kp;
      logic [GAIN_W-1:0]     dist_ki;
      logic [GAIN_W-1:0]     dist_kd;
      logic [GAIN_W-1:0]     speed_kp;
      logic [GAIN_W-1:0]     speed_ki;
   } cfg_type;

endpackage

### hw/rtl/fwcpid_ifs.sv
// fwcpid_req_if and fwcpid_rsp_if: valid/ready channels of the cascaded wheel regulator
// depends on fwcpid_pkg for the field widths

interface fwcpid_req_if;
   logic                                valid;
   logic                                ready;
   logic [fwcpid_pkg::REQ_TYPE_W-1:0]    req_type;
   logic [fwcpid_pkg::WHEEL_FIELD_W-1:0] wheel;

   modport source (output valid, req_type, wheel, input ready);
   modport sink   (input valid, req_type, wheel, output ready);
endinterface

interface fwcpid_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [fwcpid_pkg::DRIVE_W-1:0] drive_front_left;
   logic signed [fwcpid_pkg::DRIVE_W-1:0] drive_rear_left;
   logic signed [fwcpid_pkg::DRIVE_W-1:0] drive_front_right;
   logic signed [fwcpid_pkg::DRIVE_W-1:0] drive_rear_right;
   logic                                move_done;

   modport source (output valid, drive_front_left, drive_rear_left, drive_front_right,
                   drive_rear_right, move_done, input ready);
   modport sink   (input valid, drive_front_left, drive_rear_left, drive_front_right,
                   drive_rear_right, move_done, output ready);
endinterface

### hw/rtl/fwcpid_front.sv
// fwcpid_front: takes request words and turns them into commands for the queue
// depends on fwcpid_pkg and fwcpid_req_if

module fwcpid_front (
   input  logic                clock,
   input  logic                reset,
   fwcpid_req_if.sink          req_ch,
   output logic                push_valid,
   output fwcpid_pkg::cmd_type push_cmd,
   input  logic                push_ready
);

   logic                hold_valid_ff, hold_valid_in;
   fwcpid_pkg::cmd_type hold_cmd_ff, hold_cmd_in;
   fwcpid_pkg::cmd_type cmd_class;
   logic                req_take;

   // pulses for absent wheels and the unused code only report
   always_comb begin
      cmd_class.wheel = fwcpid_pkg::WHEEL_IDX_W'(req_ch.wheel);
      unique case (req_ch.req_type)
         fwcpid_pkg::REQ_PULSE: begin
            if (int'(req_ch.wheel) < fwcpid_pkg::WHEELS) begin
               cmd_class.kind = fwcpid_pkg::CMD_PULSE;
            end else begin
               cmd_class.kind = fwcpid_pkg::CMD_REPORT;
            end
         end
         fwcpid_pkg::REQ_TICK:  cmd_class.kind = fwcpid_pkg::CMD_TICK;
         fwcpid_pkg::REQ_START: cmd_class.kind = fwcpid_pkg::CMD_START;
         default:               cmd_class.kind = fwcpid_pkg::CMD_REPORT;
      endcase
   end

   assign req_ch.ready = !hold_valid_ff || push_ready;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign push_valid   = hold_valid_ff;
   assign push_cmd     = hold_cmd_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_cmd_in   = hold_cmd_ff;
      if (req_take) begin
         hold_valid_in = 1'b1;
         hold_cmd_in   = cmd_class;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_cmd_ff <= hold_cmd_in;
   end

endmodule

### hw/rtl/fwcpid_queue.sv
// fwcpid_queue: short command queue between the front and the back of the regulator
// depends on fwcpid_pkg for the command type and depth

module fwcpid_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  fwcpid_pkg::cmd_type push_cmd,
   output logic                push_ready,
   output logic                pop_valid,
   output fwcpid_pkg::cmd_type pop_cmd,
   input  logic                pop_ready
);

   fwcpid_pkg::cmd_type              slot_ff [fwcpid_pkg::QUEUE_DEPTH];
   logic [fwcpid_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [fwcpid_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [fwcpid_pkg::QCNT_W-1:0]     cnt_ff, cnt_in;
   logic                             do_push, do_pop;

   localparam logic [fwcpid_pkg::QPTR_W-1:0] LAST_SLOT =
      fwcpid_pkg::QPTR_W'(fwcpid_pkg::QUEUE_DEPTH - 1);

   assign push_ready = (cnt_ff != fwcpid_pkg::QCNT_W'(fwcpid_pkg::QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hw/rtl/fwcpid_back.sv
// fwcpid_back: executes queued commands on the wheel state with one shared multiplier
// depends on fwcpid_pkg and fwcpid_rsp_if

module fwcpid_back (
   input  logic                clock,
   input  logic                reset,
   input  fwcpid_pkg::cfg_type cfg,
   input  logic                q_valid,
   input  fwcpid_pkg::cmd_type q_cmd,
   output logic                q_pop,
   fwcpid_rsp_if.source        rsp_ch
);

   localparam int WHEELS  = fwcpid_pkg::WHEELS;
   localparam int IDX_W   = fwcpid_pkg::WHEEL_IDX_W;
   localparam int COUNT_W = fwcpid_pkg::COUNT_W;
   localparam int DERR_W  = fwcpid_pkg::DERR_W;
   localparam int DDIFF_W = fwcpid_pkg::DDIFF_W;
   localparam int SUM_W   = fwcpid_pkg::SUM_W;
   localparam int SDIFF_W = fwcpid_pkg::SDIFF_W;
   localparam int PROD_W  = fwcpid_pkg::PROD_W;
   localparam int ACC_W   = fwcpid_pkg::ACC_W;
   localparam int SCL_W   = fwcpid_pkg::SCL_W;
   localparam int DRIVE_W = fwcpid_pkg::DRIVE_W;
   localparam int GAIN_W  = fwcpid_pkg::GAIN_W;
   localparam int FRAC    = fwcpid_pkg::GAIN_FRAC_BITS;
   localparam int DSUM_W  = SCL_W + 1;
   localparam int FIELDS  = fwcpid_pkg::DRIVE_FIELDS;

   localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'((64'd1 << FRAC) - 64'd1);
   localparam logic [IDX_W-1:0] LAST_WHEEL = IDX_W'(WHEELS - 1);

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_TICK = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   // per-wheel steps of a tick
   localparam logic [3:0] PH_ERR    = 4'd0;
   localparam logic [3:0] PH_M_KP   = 4'd1;
   localparam logic [3:0] PH_M_KI   = 4'd2;
   localparam logic [3:0] PH_M_KD   = 4'd3;
   localparam logic [3:0] PH_ACC_D  = 4'd4;
   localparam logic [3:0] PH_SPD    = 4'd5;
   localparam logic [3:0] PH_SE     = 4'd6;
   localparam logic [3:0] PH_SDIFF  = 4'd7;
   localparam logic [3:0] PH_M_SKP  = 4'd8;
   localparam logic [3:0] PH_M_SKI  = 4'd9;
   localparam logic [3:0] PH_ACC_S  = 4'd10;
   localparam logic [3:0] PH_INC    = 4'd11;
   localparam logic [3:0] PH_DRV    = 4'd12;

   function automatic logic signed [SCL_W-1:0] gain_shift(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] biased;
      biased = v + (v[ACC_W-1] ? ROUND_BIAS : '0);
      return biased[ACC_W-1:FRAC];
   endfunction

   function automatic logic signed [SUM_W-1:0] sat_scl(input logic signed [SCL_W-1:0] v);
      logic [SCL_W-SUM_W:0] hi;
      hi = v[SCL_W-1:SUM_W-1];
      if (&hi || ~|hi) begin
         return v[SUM_W-1:0];
      end
      return v[SCL_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
   endfunction

   function automatic logic signed [SUM_W-1:0] sat_wide(input logic signed [SUM_W:0] v);
      if (v[SUM_W] == v[SUM_W-1]) begin
         return v[SUM_W-1:0];
      end
      return v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
   endfunction

   function automatic logic signed [DRIVE_W-1:0] sat_drive(input logic signed [DSUM_W-1:0] v);
      logic [DSUM_W-DRIVE_W:0] hi;
      hi = v[DSUM_W-1:DRIVE_W-1];
      if (&hi || ~|hi) begin
         return v[DRIVE_W-1:0];
      end
      return v[DSUM_W-1] ? {1'b1, {(DRIVE_W-1){1'b0}}} : {1'b0, {(DRIVE_W-1){1'b1}}};
   endfunction

   // wheel state
   logic        [COUNT_W-1:0] period_ff  [WHEELS], period_in  [WHEELS];
   logic        [COUNT_W-1:0] total_ff   [WHEELS], total_in   [WHEELS];
   logic signed [DERR_W-1:0]  last_e_ff  [WHEELS], last_e_in  [WHEELS];
   logic signed [SUM_W-1:0]   esum_ff    [WHEELS], esum_in    [WHEELS];
   logic signed [SUM_W-1:0]   last_se_ff [WHEELS], last_se_in [WHEELS];
   logic signed [DRIVE_W-1:0] drive_ff   [WHEELS], drive_in   [WHEELS];

   // sequencer and working registers
   logic [1:0]                st_ff, st_in;
   logic [3:0]                ph_ff, ph_in;
   logic [IDX_W-1:0]          wh_ff, wh_in;
   logic signed [DERR_W-1:0]  e_ff, e_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [DDIFF_W-1:0] dd_ff, dd_in;
   logic signed [SUM_W-1:0]   spd_ff, spd_in;
   logic signed [SUM_W-1:0]   se_ff, se_in;
   logic signed [SDIFF_W-1:0] sd_ff, sd_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [SCL_W-1:0]   inc_ff, inc_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DRIVE_W-1:0] rsp_drive_ff [FIELDS], rsp_drive_in [FIELDS];
   logic                      rsp_done_ff, rsp_done_in;

   logic [IDX_W-1:0]          idx;
   logic [GAIN_W-1:0]         mul_gain;
   logic signed [SDIFF_W-1:0] mul_b;
   logic signed [GAIN_W:0]    mul_a;
   logic signed [SUM_W:0]     wide_sum;
   logic signed [DSUM_W-1:0]  drive_sum;
   logic signed [DRIVE_W-1:0] drive_field [FIELDS];
   logic                      done_now;
   logic                      rsp_free;

   for (genvar f = 0; f < FIELDS; f++) begin : g_field
      if (f < WHEELS) begin : g_present
         assign drive_field[f] = drive_ff[f];
      end else begin : g_absent
         assign drive_field[f] = '0;
      end
   end

   always_comb begin
      done_now = 1'b0;
      for (int w = 0; w < WHEELS; w++) begin
         if (total_ff[w] > cfg.target_pulses) begin
            done_now = 1'b1;
         end
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign q_pop    = q_valid && (st_ff == ST_IDLE);
   assign idx      = (st_ff == ST_IDLE) ? q_cmd.wheel : wh_ff;

   // shared 17x33 multiplier, registered output
   assign mul_a   = $signed({1'b0, mul_gain});
   assign prod_in = mul_a * mul_b;

   always_comb begin
      st_in        = st_ff;
      ph_in        = ph_ff;
      wh_in        = wh_ff;
      period_in    = period_ff;
      total_in     = total_ff;
      last_e_in    = last_e_ff;
      esum_in      = esum_ff;
      last_se_in   = last_se_ff;
      drive_in     = drive_ff;
      e_in         = e_ff;
      sum_in       = sum_ff;
      dd_in        = dd_ff;
      spd_in       = spd_ff;
      se_in        = se_ff;
      sd_in        = sd_ff;
      acc_in       = acc_ff;
      inc_in       = inc_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      mul_gain     = '0;
      mul_b        = '0;
      wide_sum     = '0;
      drive_sum    = '0;

      unique case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               unique case (q_cmd.kind)
                  fwcpid_pkg::CMD_PULSE: begin
                     if (period_ff[idx] != '1) begin
                        period_in[idx] = period_ff[idx] + 1'b1;
                     end
                     if (total_ff[idx] != '1) begin
                        total_in[idx] = total_ff[idx] + 1'b1;
                     end
                     st_in = ST_EMIT;
                  end
                  fwcpid_pkg::CMD_TICK: begin
                     wh_in = '0;
                     ph_in = PH_ERR;
                     st_in = ST_TICK;
                  end
                  fwcpid_pkg::CMD_START: begin
                     for (int w = 0; w < WHEELS; w++) begin
                        total_in[w]   = '0;
                        last_e_in[w]  = '0;
                        esum_in[w]    = '0;
                        last_se_in[w] = '0;
                        drive_in[w]   = '0;
                     end
                     st_in = ST_EMIT;
                  end
                  fwcpid_pkg::CMD_REPORT: begin
                     st_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_TICK: begin
            ph_in = ph_ff + 1'b1;
            unique case (ph_ff)
               PH_ERR: begin
                  e_in     = $signed({1'b0, cfg.target_pulses}) - $signed({1'b0, total_ff[idx]});
                  wide_sum = (SUM_W + 1)'(esum_ff[idx]) + (SUM_W + 1)'(e_in);
                  sum_in   = sat_wide(wide_sum);
                  dd_in    = DDIFF_W'(e_in) - DDIFF_W'(last_e_ff[idx]);
               end
               PH_M_KP: begin
                  mul_gain = cfg.dist_kp;
                  mul_b    = SDIFF_W'(e_ff);
               end
               PH_M_KI: begin
                  mul_gain = cfg.dist_ki;
                  mul_b    = SDIFF_W'(sum_ff);
                  acc_in   = ACC_W'(prod_ff);
               end
               PH_M_KD: begin
                  mul_gain = cfg.dist_kd;
                  mul_b    = SDIFF_W'(dd_ff);
                  acc_in   = acc_ff + ACC_W'(prod_ff);
               end
               PH_ACC_D: begin
                  acc_in = acc_ff + ACC_W'(prod_ff);
               end
               PH_SPD: begin
                  spd_in = sat_scl(gain_shift(acc_ff));
               end
               PH_SE: begin
                  wide_sum = (SUM_W + 1)'(spd_ff) - $signed({{(SUM_W + 1 - COUNT_W){1'b0}},
                                                             period_ff[idx]});
                  se_in    = sat_wide(wide_sum);
               end
               PH_SDIFF: begin
                  sd_in = SDIFF_W'(se_ff) - SDIFF_W'(last_se_ff[idx]);
               end
               PH_M_SKP: begin
                  mul_gain = cfg.speed_kp;
                  mul_b    = sd_ff;
               end
               PH_M_SKI: begin
                  mul_gain = cfg.speed_ki;
                  mul_b    = SDIFF_W'(se_ff);
                  acc_in   = ACC_W'(prod_ff);
               end
               PH_ACC_S: begin
                  acc_in = acc_ff + ACC_W'(prod_ff);
               end
               PH_INC: begin
                  inc_in = gain_shift(acc_ff);
               end
               PH_DRV: begin
                  drive_sum       = DSUM_W'(drive_ff[idx]) + DSUM_W'(inc_ff);
                  drive_in[idx]   = sat_drive(drive_sum);
                  esum_in[idx]    = sum_ff;
                  last_e_in[idx]  = e_ff;
                  last_se_in[idx] = se_ff;
                  period_in[idx]  = '0;
                  ph_in           = PH_ERR;
                  if (wh_ff == LAST_WHEEL) begin
                     st_in = ST_EMIT;
                  end else begin
                     wh_in = wh_ff + 1'b1;
                  end
               end
               default: begin
                  ph_in = PH_ERR;
               end
            endcase
         end
         ST_EMIT: begin
            if (rsp_free) begin
               for (int f = 0; f < FIELDS; f++) begin
                  rsp_drive_in[f] = drive_field[f];
               end
               rsp_done_in  = done_now;
               rsp_valid_in = 1'b1;
               st_in        = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         ph_ff        <= PH_ERR;
         wh_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         period_ff    <= '{default: '0};
         total_ff     <= '{default: '0};
         last_e_ff    <= '{default: '0};
         esum_ff      <= '{default: '0};
         last_se_ff   <= '{default: '0};
         drive_ff     <= '{default: '0};
      end else begin
         st_ff        <= st_in;
         ph_ff        <= ph_in;
         wh_ff        <= wh_in;
         rsp_valid_ff <= rsp_valid_in;
         period_ff    <= period_in;
         total_ff     <= total_in;
         last_e_ff    <= last_e_in;
         esum_ff      <= esum_in;
         last_se_ff   <= last_se_in;
         drive_ff     <= drive_in;
      end
      e_ff         <= e_in;
      sum_ff       <= sum_in;
      dd_ff        <= dd_in;
      spd_ff       <= spd_in;
      se_ff        <= se_in;
      sd_ff        <= sd_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      inc_ff       <= inc_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.drive_front_left  = rsp_drive_ff[0];
   assign rsp_ch.drive_rear_left   = rsp_drive_ff[1];
   assign rsp_ch.drive_front_right = rsp_drive_ff[2];
   assign rsp_ch.drive_rear_right  = rsp_drive_ff[3];
   assign rsp_ch.move_done         = rsp_done_ff;

   // wheel sweep moves on to the next wheel from its first step
   a_next_wheel: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_TICK && ph_ff == PH_DRV && wh_ff != LAST_WHEEL) |=>
      (st_ff == ST_TICK && ph_ff == PH_ERR && wh_ff == IDX_W'($past(wh_ff) + 1'b1)))
      else $error("tick sweep did not advance to the next wheel");

   a_sweep_end: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_TICK && ph_ff == PH_DRV && wh_ff == LAST_WHEEL) |=> (st_ff == ST_EMIT))
      else $error("tick sweep did not end in the report step");

   a_start_clear: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_cmd.kind == fwcpid_pkg::CMD_START) |=>
      (drive_ff[0] == '0 && total_ff[0] == '0 && esum_ff[0] == '0))
      else $error("start command left wheel state set");

   a_emit: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_EMIT && rsp_free) |=> (rsp_valid_ff && st_ff == ST_IDLE))
      else $error("report step did not load the result register");

endmodule

### hw/rtl/four_wheel_cascaded_pid.sv
// four_wheel_cascaded_pid: top level of the four-wheel cascaded position/speed regulator
// depends on fwcpid_pkg, fwcpid_ifs, fwcpid_front, fwcpid_queue and fwcpid_back
//
// req_ch carries one word per event: an encoder pulse for one wheel, a control tick
// or the start of a new move. rsp_ch returns exactly one word for every request word:
// the four drive levels after that event and the move_done flag. both are valid/ready
// channels; a word moves on a rising edge with valid and ready high.
// csr_we/csr_index/csr_wdata write the target and the five gains, one register a cycle;
// the user must write them only while no request is in flight; the block does not enforce it.
// the front stage registers and classifies each request and hands it to a two-entry
// command queue; the back end works through the queue one command at a time.
// a request passes the front register and the queue before it reaches the back end.
// a pulse, start or unused code then goes from the fetch state to the report state; a
// tick runs 13 steps per wheel for each of the 4 wheels between fetch and report.
// the tick time is set by the one shared 17x33 multiplier that the back end steps
// through the five gain products of each wheel in turn.
// a finished result sits in the output register while the front keeps taking requests
// until the queue is full; a stalled receiver then backs up to req_ch.ready.
// reset clears the wheel counts, errors, sums and drives and loads the default target
// and gains; the block is ready for requests as soon as reset is low.

module four_wheel_cascaded_pid (
   input  logic                                clock,
   input  logic                                reset,
   fwcpid_req_if.sink                          req_ch,
   fwcpid_rsp_if.source                        rsp_ch,
   input  logic                                csr_we,
   input  logic [fwcpid_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fwcpid_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   fwcpid_pkg::cfg_type cfg_ff, cfg_in;

   // command hand-off between front and queue, queue and back end
   logic                push_valid;
   fwcpid_pkg::cmd_type push_cmd;
   logic                push_ready;
   logic                pop_valid;
   fwcpid_pkg::cmd_type pop_cmd;
   logic                pop_ready;

   // register file: writes beyond the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            fwcpid_pkg::CSR_TARGET:   cfg_in.target_pulses = csr_wdata;
            fwcpid_pkg::CSR_DIST_KP:  cfg_in.dist_kp       = csr_wdata;
            fwcpid_pkg::CSR_DIST_KI:  cfg_in.dist_ki       = csr_wdata;
            fwcpid_pkg::CSR_DIST_KD:  cfg_in.dist_kd       = csr_wdata;
            fwcpid_pkg::CSR_SPEED_KP: cfg_in.speed_kp      = csr_wdata;
            fwcpid_pkg::CSR_SPEED_KI: cfg_in.speed_ki      = csr_wdata;
            default:                  cfg_in               = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_pulses <= fwcpid_pkg::TARGET_RST;
         cfg_ff.dist_kp       <= fwcpid_pkg::DIST_KP_RST;
         cfg_ff.dist_ki       <= fwcpid_pkg::DIST_KI_RST;
         cfg_ff.dist_kd       <= fwcpid_pkg::DIST_KD_RST;
         cfg_ff.speed_kp      <= fwcpid_pkg::SPEED_KP_RST;
         cfg_ff.speed_ki      <= fwcpid_pkg::SPEED_KI_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: request register and classification
   fwcpid_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   // queue: lets the front run ahead of a long tick
   fwcpid_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   // back end: wheel state, loop arithmetic and result register
   fwcpid_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (pop_valid),
      .q_cmd   (pop_cmd),
      .q_pop   (pop_ready),
      .rsp_ch  (rsp_ch)
   );

endmodule

### test/four_wheel_cascaded_pid_tb.sv
`timescale 1ns / 1ps
// four_wheel_cascaded_pid_tb: self-checking bench for the cascaded four-wheel regulator
// depends on fwcpid_pkg, fwcpid_ifs and four_wheel_cascaded_pid; drives valid/ready words
// and csr writes, predicts every report word in a scoreboard class and checks it

typedef struct packed {
   logic [15:0] front_left;
   logic [15:0] rear_left;
   logic [15:0] front_right;
   logic [15:0] rear_right;
   logic        move_done;
} drive_report_type;

// keeps its own copy of the wheel counts, loop memories and gains, and the
// queue of report words that the block still owes
class wheel_regulator_board;
   localparam longint S32_MIN = -64'sd2147483648;
   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint DRV_MIN = -64'sd32768;
   localparam longint DRV_MAX = 64'sd32767;

   bit [15:0] target_pulses;
   bit [15:0] dist_kp;
   bit [15:0] dist_ki;
   bit [15:0] dist_kd;
   bit [15:0] speed_kp;
   bit [15:0] speed_ki;

   bit [15:0] period_count[4];
   bit [15:0] total_count[4];
   longint    last_dist_err[4];
   longint    dist_err_sum[4];
   longint    last_speed_err[4];
   longint    drive_level[4];

   drive_report_type reports_due[$];
   int               mismatches;
   int               reports_checked;

   function new();
      target_pulses = fwcpid_pkg::TARGET_RST;
      dist_kp       = fwcpid_pkg::DIST_KP_RST;
      dist_ki       = fwcpid_pkg::DIST_KI_RST;
      dist_kd       = fwcpid_pkg::DIST_KD_RST;
      speed_kp      = fwcpid_pkg::SPEED_KP_RST;
      speed_ki      = fwcpid_pkg::SPEED_KI_RST;
      for (int w = 0; w < 4; w++) begin
         period_count[w]   = '0;
         total_count[w]    = '0;
         last_dist_err[w]  = 0;
         dist_err_sum[w]   = 0;
         last_speed_err[w] = 0;
         drive_level[w]    = 0;
      end
      mismatches      = 0;
      reports_checked = 0;
   endfunction

   function void set_register(bit [2:0] idx, bit [15:0] value);
      case (idx)
         fwcpid_pkg::CSR_TARGET:   target_pulses = value;
         fwcpid_pkg::CSR_DIST_KP:  dist_kp = value;
         fwcpid_pkg::CSR_DIST_KI:  dist_ki = value;
         fwcpid_pkg::CSR_DIST_KD:  dist_kd = value;
         fwcpid_pkg::CSR_SPEED_KP: speed_kp = value;
         fwcpid_pkg::CSR_SPEED_KI: speed_ki = value;
         default: ;
      endcase
   endfunction

   function longint limit_to(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // division rounds toward zero, as the gain shift must
   function longint gain_shift(longint acc);
      return acc / (longint'(1) << fwcpid_pkg::GAIN_FRAC_BITS);
   endfunction

   function void run_wheel_loops(int w);
      longint e;
      longint sum;
      longint acc;
      longint spd;
      longint se;
      longint inc;
      e   = longint'(target_pulses) - longint'(total_count[w]);
      sum = limit_to(dist_err_sum[w] + e, S32_MIN, S32_MAX);
      acc = longint'(dist_kp) * e + longint'(dist_ki) * sum
          + longint'(dist_kd) * (e - last_dist_err[w]);
      spd = limit_to(gain_shift(acc), S32_MIN, S32_MAX);
      se  = limit_to(spd - longint'(period_count[w]), S32_MIN, S32_MAX);
      inc = longint'(speed_kp) * (se - last_speed_err[w]) + longint'(speed_ki) * se;
      drive_level[w]    = limit_to(drive_level[w] + gain_shift(inc), DRV_MIN, DRV_MAX);
      dist_err_sum[w]   = sum;
      last_dist_err[w]  = e;
      last_speed_err[w] = se;
      period_count[w]   = '0;
   endfunction

   function void note_request(bit [1:0] kind, bit [1:0] wheel);
      drive_report_type rpt;
      bit               done;
      case (kind)
         fwcpid_pkg::REQ_PULSE: begin
            if (int'(wheel) < fwcpid_pkg::WHEELS) begin
               if (period_count[wheel] != 16'hFFFF) period_count[wheel]++;
               if (total_count[wheel] != 16'hFFFF) total_count[wheel]++;
            end
         end
         fwcpid_pkg::REQ_TICK: begin
            for (int w = 0; w < 4; w++) run_wheel_loops(w);
         end
         fwcpid_pkg::REQ_START: begin
            for (int w = 0; w < 4; w++) begin
               total_count[w]    = '0;
               last_dist_err[w]  = 0;
               dist_err_sum[w]   = 0;
               last_speed_err[w] = 0;
               drive_level[w]    = 0;
            end
         end
         default: ;
      endcase
      done = 1'b0;
      for (int w = 0; w < 4; w++)
         if (total_count[w] > target_pulses) done = 1'b1;
      rpt.front_left  = 16'(drive_level[0]);
      rpt.rear_left   = 16'(drive_level[1]);
      rpt.front_right = 16'(drive_level[2]);
      rpt.rear_right  = 16'(drive_level[3]);
      rpt.move_done   = done;
      reports_due.push_back(rpt);
   endfunction

   function void compare_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   function void check_report(drive_report_type got);
      drive_report_type want;
      if (reports_due.size() == 0) begin
         $error("report word with no request waiting for it");
         mismatches++;
         return;
      end
      want = reports_due.pop_front();
      reports_checked++;
      compare_field("drive_front_left", $signed(want.front_left), $signed(got.front_left));
      compare_field("drive_rear_left", $signed(want.rear_left), $signed(got.rear_left));
      compare_field("drive_front_right", $signed(want.front_right),
                    $signed(got.front_right));
      compare_field("drive_rear_right", $signed(want.rear_right), $signed(got.rear_right));
      compare_field("move_done", int'(want.move_done), int'(got.move_done));
   endfunction
endclass

module four_wheel_cascaded_pid_tb;

   // the one request code that the package leaves unnamed
   localparam logic [fwcpid_pkg::REQ_TYPE_W-1:0] REQ_UNUSED   = 2'd3;
   // first register index past the list, writes there must change nothing
   localparam logic [fwcpid_pkg::CSR_IDX_W-1:0]  CSR_PAST_END = 3'd6;

   localparam int SAT_TICKS       = 32;     // enough for the drives to reach their limits
   localparam int RANDOM_PHASES   = 8;
   localparam int WORDS_PER_PHASE = 100;
   localparam int DRAIN_CYCLES    = 64;     // room for a tick to run through the back end
   localparam int CYCLE_LIMIT     = 400_000;

   typedef enum {
      PACE_STEADY,
      PACE_SENDER_GAPS,
      PACE_RECEIVER_STALLS,
      PACE_BOTH
   } pacing_mode_type;

   logic                              clock;
   logic                              reset;
   logic                              csr_we;
   logic [fwcpid_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [fwcpid_pkg::CSR_DATA_W-1:0] csr_wdata;

   fwcpid_req_if req_ch ();
   fwcpid_rsp_if rsp_ch ();

   wheel_regulator_board board;

   int sender_pct;
   int receiver_pct;
   int words_sent;
   int ticks_sent;
   int settings_used;

   four_wheel_cascaded_pid DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // receiver side: stall at random when the phase asks for it
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= receiver_pct);
   end

   // both channels are sampled at the edge, before anything driven at that edge lands;
   // the report is checked before the new request is noted, so a word can never be
   // matched against its own request
   always @(posedge clock) begin : watch_channels
      drive_report_type seen;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen = {rsp_ch.drive_front_left, rsp_ch.drive_rear_left,
                    rsp_ch.drive_front_right, rsp_ch.drive_rear_right, rsp_ch.move_done};
            board.check_report(seen);
         end
         if (req_ch.valid && req_ch.ready)
            board.note_request(req_ch.req_type, req_ch.wheel);
      end
   end

   // hang guard
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("four_wheel_cascaded_pid_tb: done, errors");
      $finish;
   end

   task automatic set_pacing(input pacing_mode_type mode);
      case (mode)
         PACE_STEADY: begin
            sender_pct   = 0;
            receiver_pct = 0;
         end
         PACE_SENDER_GAPS: begin
            sender_pct   = 46;
            receiver_pct = 0;
         end
         PACE_RECEIVER_STALLS: begin
            sender_pct   = 0;
            receiver_pct = 46;
         end
         default: begin
            sender_pct   = 23;
            receiver_pct = 23;
         end
      endcase
   endtask

   // one request word; valid stays high afterwards so back-to-back words need no bubble,
   // and junk rides on the fields while valid is low
   task automatic send_word(input logic [fwcpid_pkg::REQ_TYPE_W-1:0] kind,
                            input logic [fwcpid_pkg::WHEEL_FIELD_W-1:0] wheel);
      while ($urandom_range(99) < sender_pct) begin
         req_ch.valid    <= 1'b0;
         req_ch.req_type <= 2'($urandom);
         req_ch.wheel    <= 2'($urandom);
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= kind;
      req_ch.wheel    <= wheel;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      words_sent++;
      if (kind == fwcpid_pkg::REQ_TICK) ticks_sent++;
   endtask

   // drop valid and wait until every accepted word has had its report checked
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (board.reports_checked < words_sent || board.reports_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [fwcpid_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [fwcpid_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      board.set_register(idx, value);
   endtask

   // all six registers plus one write past the list, only called while idle
   task automatic write_settings(input logic [15:0] target, input logic [15:0] dkp,
                                 input logic [15:0] dki, input logic [15:0] dkd,
                                 input logic [15:0] skp, input logic [15:0] ski);
      write_register(fwcpid_pkg::CSR_TARGET, target);
      write_register(fwcpid_pkg::CSR_DIST_KP, dkp);
      write_register(fwcpid_pkg::CSR_DIST_KI, dki);
      write_register(fwcpid_pkg::CSR_DIST_KD, dkd);
      write_register(fwcpid_pkg::CSR_SPEED_KP, skp);
      write_register(fwcpid_pkg::CSR_SPEED_KI, ski);
      write_register(CSR_PAST_END + 3'($urandom_range(1)), 16'($urandom));
      csr_we <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(3))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(4096));
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   // mostly small targets so the done flag comes and goes within a phase
   function automatic logic [15:0] pick_target();
      case ($urandom_range(9))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2, 3:    return 16'($urandom_range(65535));
         default: return 16'($urandom_range(1, 60));
      endcase
   endfunction

   // runs of pulses broken up by ticks, with the odd start and unused code
   task automatic run_random_phase(input int count);
      int                                roll;
      logic [fwcpid_pkg::REQ_TYPE_W-1:0] kind;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         if (roll < 66)      kind = fwcpid_pkg::REQ_PULSE;
         else if (roll < 86) kind = fwcpid_pkg::REQ_TICK;
         else if (roll < 93) kind = fwcpid_pkg::REQ_START;
         else                kind = REQ_UNUSED;
         send_word(kind, 2'($urandom));
      end
   endtask

   // ticks with a pulse on the front left wheel ahead of every fourth, so the
   // speed error also sees a nonzero period count
   task automatic run_saturating_ticks();
      for (int i = 0; i < SAT_TICKS; i++) begin
         if (i % 4 == 0) send_word(fwcpid_pkg::REQ_PULSE, 2'd0);
         send_word(fwcpid_pkg::REQ_TICK, 2'($urandom));
      end
   endtask

   initial begin
      board         = new();
      words_sent    = 0;
      ticks_sent    = 0;
      settings_used = 0;
      set_pacing(PACE_STEADY);
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.req_type <= fwcpid_pkg::REQ_PULSE;
      req_ch.wheel    <= '0;
      csr_we          <= 1'b0;
      csr_index       <= fwcpid_pkg::CSR_TARGET;
      csr_wdata       <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: small target so a few pulses raise the done flag, default gains
      write_register(fwcpid_pkg::CSR_TARGET, 16'd3);
      csr_we <= 1'b0;
      send_word(REQ_UNUSED, 2'd0);
      for (int w = 0; w < 4; w++) send_word(fwcpid_pkg::REQ_PULSE, 2'(w));
      send_word(fwcpid_pkg::REQ_TICK, 2'd0);
      repeat (3) send_word(fwcpid_pkg::REQ_PULSE, 2'd0);   // front left passes the target
      send_word(fwcpid_pkg::REQ_TICK, 2'd3);
      send_word(REQ_UNUSED, 2'd3);                         // only reports
      send_word(fwcpid_pkg::REQ_PULSE, 2'd1);
      send_word(fwcpid_pkg::REQ_START, 2'd2);   // period count of rear left survives this
      send_word(fwcpid_pkg::REQ_TICK, 2'd1);
      send_word(fwcpid_pkg::REQ_PULSE, 2'd2);
      send_word(fwcpid_pkg::REQ_START, 2'd0);
      settle();

      // max target and gains: every drive runs into its upper limit on the first tick
      write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_saturating_ticks();
      settle();

      // zero target on a new move: each front left pulse pushes its error below zero
      // and walks its drive down into the lower limit
      write_settings(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(fwcpid_pkg::REQ_START, 2'd0);
      run_saturating_ticks();
      settle();

      // random phases, each pacing mode twice, fresh settings and a new move each time
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_pacing(pacing_mode_type'(p % 4));
         write_settings(pick_target(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                        pick_gain());
         send_word(fwcpid_pkg::REQ_START, 2'($urandom));
         run_random_phase(WORDS_PER_PHASE);
         settle();
      end

      $display("four_wheel_cascaded_pid_tb: %0d request words (%0d ticks), %0d reports checked",
               words_sent, ticks_sent, board.reports_checked);
      $display("four_wheel_cascaded_pid_tb: %0d register settings, drive limits both ways",
               settings_used);
      if (board.mismatches == 0) begin
         $display("four_wheel_cascaded_pid_tb: done, clean");
      end else begin
         $display("four_wheel_cascaded_pid_tb: done, errors");
      end
      $finish;
   end

endmodule

### four_wheel_cascaded_pid.f
hw/rtl/fwcpid_pkg.sv
hw/rtl/fwcpid_ifs.sv
hw/rtl/fwcpid_front.sv
hw/rtl/fwcpid_queue.sv
hw/rtl/fwcpid_back.sv
hw/rtl/four_wheel_cascaded_pid.sv
test/four_wheel_cascaded_pid_tb.sv
